>>> src/sit_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and widths for the sorted insert table
package sit_pkg;

	localparam int FUNC_LEN   = 2;
	localparam int KEY_LEN    = 32;
	localparam int INDEX_LEN  = 8;
	localparam int POS_LEN    = 9;
	localparam int STATUS_LEN = 2;

	// cells are picked in groups of this size
	localparam int GROUP_SIZE  = 16;
	localparam int GROUP_SEL_W = 4;

	localparam logic [FUNC_LEN-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_LEN-1:0] FUNC_FIND   = 2'd1;
	localparam logic [FUNC_LEN-1:0] FUNC_READ   = 2'd2;

	localparam logic [STATUS_LEN-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_LEN-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_LEN-1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic [FUNC_LEN-1:0]  func;
		logic [KEY_LEN-1:0]   key;
		logic [INDEX_LEN-1:0] index;
	} sit_req_t;

	typedef struct packed {
		logic [KEY_LEN-1:0]    read_key;
		logic [POS_LEN-1:0]    position;
		logic [POS_LEN-1:0]    entry_count;
		logic [STATUS_LEN-1:0] status;
	} sit_rsp_t;

	typedef struct packed {
		logic occupied;
		logic load;
		logic shift;
	} sit_cell_ctl_t;

endpackage

>>> src/sit_stream_if.sv
`timescale 1ns / 1ps
// valid/ready stream interface carrying one word per handshake
interface sit_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/sorted_insert_table.sv
`timescale 1ns / 1ps
// Sorted key table built as a row of compare/shift cells.
// Each request passes through cell compare, group pick, and final pick and
// commit; the final step waits while the result word is still held.
// The row holds one operation at a time; a new request is taken only in idle.
// Reset clears the entry count, the compare mode and the result valid;
// cell keys are not cleared and are only read below the entry count.
module sorted_insert_table import sit_pkg::*; #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_data,
	sit_stream_if.sink         request,
	sit_stream_if.source       result
);

	localparam int KW     = KEY_WIDTH;
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int GW     = (NGROUP > 1) ? $clog2(NGROUP) : 1;
	localparam int PW     = GW + GROUP_SEL_W;
	localparam int RW     = (CW > INDEX_LEN) ? CW : INDEX_LEN;
	localparam int NPAD   = NGROUP * GROUP_SIZE;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_GRP  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]          state_q;
	logic [CW-1:0]       count_q;
	logic                sgn_q;
	logic [FUNC_LEN-1:0] func_q;
	logic [KW-1:0]       key_q;
	logic [RW-1:0]       idx_q;
	logic                out_valid_q;
	sit_rsp_t            out_q;

	logic [KW-1:0]          flip;
	logic [KW-1:0]          search_ord;
	logic [KW-1:0]          cell_key [NPAD];
	logic [NPAD-1:0]        gt_flag;
	logic                   grp_any [NGROUP];
	logic [GROUP_SEL_W-1:0] grp_first [NGROUP];
	logic [KW-1:0]          grp_key [NGROUP];
	logic [GROUP_SEL_W-1:0] local_sel;
	logic [GW-1:0]          grp_sel;

	logic          out_free;
	logic          commit;
	logic          do_insert;
	logic          full;
	logic [CW-1:0] pos;
	logic [PW-1:0] pos_w;
	logic          read_ok;
	sit_rsp_t      rsp;
	logic [CW-1:0] next_count;

	assign flip       = sgn_q ? (KW'(1) << (KW - 1)) : '0;
	assign search_ord = key_q ^ flip;
	assign local_sel  = idx_q[GROUP_SEL_W-1:0];
	assign grp_sel    = GW'(idx_q >> GROUP_SEL_W);
	assign full       = (count_q == CW'(CAPACITY));
	assign out_free   = !out_valid_q || result.ready;
	assign commit     = (state_q == ST_FIN) && out_free;
	assign do_insert  = commit && (func_q == FUNC_INSERT) && !full;
	assign read_ok    = idx_q < RW'(count_q);

	assign request.ready = (state_q == ST_IDLE);
	assign result.valid  = out_valid_q;
	assign result.data   = out_q;

	// cell row
	for (genvar i = 0; i < NPAD; i++) begin : g_cell
		if (i < CAPACITY) begin : g_real
			sit_cell_ctl_t ctl;
			logic [KW-1:0] prev;

			assign ctl.occupied = CW'(i) < count_q;
			assign ctl.load     = do_insert && (CW'(i) == pos);
			assign ctl.shift    = do_insert && (CW'(i) > pos);

			if (i == 0) begin : g_first
				assign prev = key_q;
			end else begin : g_next
				assign prev = cell_key[i-1];
			end

			sit_cell #(.KW(KW)) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.flip       (flip),
				.search_ord (search_ord),
				.new_key    (key_q),
				.prev_key   (prev),
				.key_q      (cell_key[i]),
				.gt_s1      (gt_flag[i])
			);
		end else begin : g_pad
			assign cell_key[i] = '0;
			assign gt_flag[i]  = 1'b0;
		end
	end

	// group pick stage
	for (genvar g = 0; g < NGROUP; g++) begin : g_grp
		sit_group #(.KW(KW)) u_group (
			.clk      (clk),
			.flags    (gt_flag[g*GROUP_SIZE +: GROUP_SIZE]),
			.keys     (cell_key[g*GROUP_SIZE +: GROUP_SIZE]),
			.sel      (local_sel),
			.any_s2   (grp_any[g]),
			.first_s2 (grp_first[g]),
			.rkey_s2  (grp_key[g])
		);
	end

	// first group holding a greater key, else the count
	always_comb begin
		pos_w = '0;
		pos   = count_q;
		for (int g = NGROUP - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				pos_w = {GW'(g), grp_first[g]};
				pos   = CW'(pos_w);
			end
		end
	end

	always_comb begin
		rsp        = '0;
		rsp.status = STATUS_OK;
		next_count = count_q;
		unique case (func_q)
			FUNC_INSERT: begin
				rsp.position = POS_LEN'(pos);
				if (full) begin
					rsp.status = STATUS_FULL;
				end else begin
					next_count = count_q + CW'(1);
				end
			end
			FUNC_FIND: begin
				rsp.position = POS_LEN'(pos);
			end
			FUNC_READ: begin
				if (read_ok) begin
					rsp.read_key = KEY_LEN'(grp_key[grp_sel]);
				end else begin
					rsp.status = STATUS_RANGE;
				end
			end
			default: begin
			end
		endcase
		rsp.entry_count = POS_LEN'(next_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sgn_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				sgn_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (request.valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_GRP;
				end
				ST_GRP: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit) begin
				count_q     <= next_count;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			func_q <= request.data.func;
			key_q  <= KW'(request.data.key);
			idx_q  <= RW'(request.data.index);
		end
		if (commit) begin
			out_q <= rsp;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result word raised outside the final step");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && func_q == FUNC_INSERT && full) |=> $stable(count_q))
		else $error("refused insert changed the entry count");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FIN) |=> $stable(count_q))
		else $error("entry count changed outside commit");

endmodule

>>> src/sit_cell.sv
`timescale 1ns / 1ps
// one table cell: holds a key, compares it with the search key, shifts up
module sit_cell import sit_pkg::*; #(
	parameter int KW = 32
) (
	input  logic          clk,
	input  sit_cell_ctl_t ctl,
	input  logic [KW-1:0] flip,
	input  logic [KW-1:0] search_ord,
	input  logic [KW-1:0] new_key,
	input  logic [KW-1:0] prev_key,
	output logic [KW-1:0] key_q,
	output logic          gt_s1
);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q <= new_key;
		end else if (ctl.shift) begin
			key_q <= prev_key;
		end
		// xor with flip turns a signed order into an unsigned one
		gt_s1 <= ctl.occupied & ((key_q ^ flip) > search_ord);
	end

endmodule

>>> src/sit_group.sv
`timescale 1ns / 1ps
// first greater cell and read select within one group of cells
module sit_group import sit_pkg::*; #(
	parameter int KW = 32
) (
	input  logic                   clk,
	input  logic [GROUP_SIZE-1:0]  flags,
	input  logic [KW-1:0]          keys [GROUP_SIZE],
	input  logic [GROUP_SEL_W-1:0] sel,
	output logic                   any_s2,
	output logic [GROUP_SEL_W-1:0] first_s2,
	output logic [KW-1:0]          rkey_s2
);

	logic [GROUP_SEL_W-1:0] first;

	always_comb begin
		first = '0;
		for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
			if (flags[i]) begin
				first = GROUP_SEL_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		any_s2   <= |flags;
		first_s2 <= first;
		rkey_s2  <= keys[sel];
	end

endmodule
